/* rtl/core/lrat_pkg.sv */
`default_nettype none
package lrat_pkg;

	localparam int DW = 32;
	localparam int FW = 11;
	localparam logic signed [DW-1:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [DW-1:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [DW-1:0] EMPTY_RESET = 32'sd1000000000;

	typedef enum logic {
		ACT_ADD   = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	// one tree node as stored in the node RAM
	typedef struct packed {
		logic                 flag;
		logic signed [DW-1:0] pend;
		logic signed [DW-1:0] nmin;
	} node_t;

	typedef struct packed {
		logic signed [DW-1:0] add_amount;
		logic [FW-1:0]        range_end;
		logic [FW-1:0]        range_start;
		action_t              action;
	} item_t;

	typedef enum logic [2:0] {
		W_CLR,
		W_IDLE,
		W_DISP,
		W_SRD,
		W_SCHK,
		W_MRD,
		W_MWR,
		W_FIN
	} wstate_t;

	// what a stack frame does next when control returns to it
	typedef enum logic [2:0] {
		P_ENTER,
		P_TEST,
		P_RIGHT,
		P_FIX,
		P_FIX2,
		P_FIX3,
		P_COVSET,
		P_POP
	} phase_t;

	function automatic logic signed [DW-1:0] sat_add(logic signed [DW-1:0] a,
		logic signed [DW-1:0] b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		if (s[DW] != s[DW-1]) begin
			return s[DW] ? S32_MIN : S32_MAX;
		end
		return s[DW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] min_s(logic signed [DW-1:0] a,
		logic signed [DW-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/lrat_node_ram.sv */
`default_nettype none
module lrat_node_ram #(
	parameter int AW = 11
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   addr,
	input  wire lrat_pkg::node_t wdata,
	output lrat_pkg::node_t      rdata
);
	import lrat_pkg::*;

	node_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

/* rtl/core/lrat_walker.sv */
`default_nettype none
module lrat_walker #(
	parameter int LEAVES = 1024,
	parameter int AW     = 11
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire lrat_pkg::item_t        item,
	input  wire logic signed [31:0]     empty_val,
	output logic                        ready,
	output logic                        res_valid,
	input  wire logic                   res_ready,
	output logic signed [31:0]          res_min,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_addr,
	output lrat_pkg::node_t             mem_wdata,
	input  wire lrat_pkg::node_t        mem_rdata
);
	import lrat_pkg::*;

	localparam int LVL = AW;
	localparam int SW  = (LVL > 1) ? $clog2(LVL) : 1;
	localparam logic [AW-1:0] NLEAF = AW'(LEAVES);

	wstate_t state_q, state_d;
	logic [SW-1:0] sp_q;
	logic [AW-1:0] nd_q [LVL];
	logic [AW-1:0] tl_q [LVL];
	logic [AW-1:0] tr_q [LVL];
	logic [AW-1:0] lo_q [LVL];
	logic [AW-1:0] hi_q [LVL];
	phase_t        ph_q [LVL];

	logic [AW-1:0] clr_q, x_q, mx_q;
	logic          two_q, qry_q;
	logic signed [31:0] amt_q, mv_q, smin_q, lmin_q, acc_q;

	logic [AW-1:0] cn, ctl, ctr, clo, chi, mid, s_sat, e_sat;
	logic          covered;
	logic signed [31:0] smin_new;

	assign cn  = nd_q[sp_q];
	assign ctl = tl_q[sp_q];
	assign ctr = tr_q[sp_q];
	assign clo = lo_q[sp_q];
	assign chi = hi_q[sp_q];
	assign mid = ctl + ((ctr - ctl) >> 1);
	assign covered = (clo == ctl) && (chi == ctr);
	assign smin_new = mem_rdata.flag ? sat_add(mem_rdata.nmin, mem_rdata.pend)
		: mem_rdata.nmin;

	assign s_sat = (32'(item.range_start) > 32'(LEAVES)) ? NLEAF : AW'(item.range_start);
	assign e_sat = (32'(item.range_end) > 32'(LEAVES)) ? NLEAF : AW'(item.range_end);

	assign ready     = (state_q == W_IDLE);
	assign res_valid = (state_q == W_FIN) && qry_q;
	assign res_min   = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_addr  = x_q;
		mem_wdata = '0;
		case (state_q)
			W_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				if (&clr_q) begin
					state_d = W_IDLE;
				end
			end
			W_IDLE: begin
				if (start) begin
					if (s_sat < e_sat) begin
						state_d = W_DISP;
					end else if (item.action == ACT_QUERY) begin
						state_d = W_FIN;
					end
				end
			end
			W_DISP: begin
				case (ph_q[sp_q])
					P_ENTER, P_FIX, P_FIX2, P_COVSET: state_d = W_SRD;
					P_TEST: begin
						if (covered && !qry_q) begin
							state_d = W_MRD;
						end else if (covered && sp_q == '0) begin
							state_d = W_FIN;
						end
					end
					P_FIX3: begin
						mem_we    = 1'b1;
						mem_addr  = cn;
						mem_wdata = '{flag: 1'b0, pend: '0, nmin: min_s(lmin_q, smin_q)};
						if (sp_q == '0) begin
							state_d = W_FIN;
						end
					end
					P_POP: begin
						if (sp_q == '0) begin
							state_d = W_FIN;
						end
					end
					default: ;
				endcase
			end
			W_SRD: state_d = W_SCHK;
			W_SCHK: begin
				state_d = W_DISP;
				if (mem_rdata.flag) begin
					mem_we    = 1'b1;
					mem_wdata = '{flag: 1'b0, pend: '0, nmin: smin_new};
					if (x_q < NLEAF) begin
						state_d = W_MRD;
					end
				end
			end
			W_MRD: begin
				mem_addr = mx_q;
				state_d  = W_MWR;
			end
			W_MWR: begin
				mem_addr  = mx_q;
				mem_we    = 1'b1;
				mem_wdata = '{flag: 1'b1, pend: sat_add(mem_rdata.pend, mv_q),
					nmin: mem_rdata.nmin};
				state_d   = two_q ? W_MRD : W_DISP;
			end
			W_FIN: begin
				if (!qry_q || res_ready) begin
					state_d = W_IDLE;
				end
			end
			default: state_d = W_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			sp_q  <= '0;
		end else begin
			if (state_q == W_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == W_IDLE) begin
				sp_q <= '0;
			end else if (state_q == W_DISP) begin
				case (ph_q[sp_q])
					P_TEST: begin
						if (covered && qry_q && sp_q != '0) begin
							sp_q <= sp_q - 1'b1;
						end else if (!covered && clo < mid) begin
							sp_q <= sp_q + 1'b1;
						end
					end
					P_RIGHT: begin
						if (chi > mid) begin
							sp_q <= sp_q + 1'b1;
						end
					end
					P_FIX3, P_POP: begin
						if (sp_q != '0) begin
							sp_q <= sp_q - 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// datapath and call stack
	always_ff @(posedge clk) begin
		case (state_q)
			W_IDLE: begin
				nd_q[0] <= AW'(1);
				tl_q[0] <= '0;
				tr_q[0] <= NLEAF;
				lo_q[0] <= s_sat;
				hi_q[0] <= e_sat;
				ph_q[0] <= P_ENTER;
				qry_q   <= (item.action == ACT_QUERY);
				amt_q   <= item.add_amount;
				acc_q   <= (s_sat < e_sat) ? S32_MAX : empty_val;
			end
			W_DISP: begin
				case (ph_q[sp_q])
					P_ENTER: begin
						x_q <= cn;
						ph_q[sp_q] <= P_TEST;
					end
					P_TEST: begin
						if (covered) begin
							if (qry_q) begin
								acc_q <= min_s(acc_q, smin_q);
							end else begin
								mx_q  <= cn;
								mv_q  <= amt_q;
								two_q <= 1'b0;
								ph_q[sp_q] <= P_COVSET;
							end
						end else begin
							ph_q[sp_q] <= P_RIGHT;
							if (clo < mid) begin
								nd_q[SW'(sp_q + 1'b1)] <= cn << 1;
								tl_q[SW'(sp_q + 1'b1)] <= ctl;
								tr_q[SW'(sp_q + 1'b1)] <= mid;
								lo_q[SW'(sp_q + 1'b1)] <= clo;
								hi_q[SW'(sp_q + 1'b1)] <= (chi < mid) ? chi : mid;
								ph_q[SW'(sp_q + 1'b1)] <= P_ENTER;
							end
						end
					end
					P_RIGHT: begin
						ph_q[sp_q] <= qry_q ? P_POP : P_FIX;
						if (chi > mid) begin
							nd_q[SW'(sp_q + 1'b1)] <= (cn << 1) | AW'(1);
							tl_q[SW'(sp_q + 1'b1)] <= mid;
							tr_q[SW'(sp_q + 1'b1)] <= ctr;
							lo_q[SW'(sp_q + 1'b1)] <= (clo > mid) ? clo : mid;
							hi_q[SW'(sp_q + 1'b1)] <= chi;
							ph_q[SW'(sp_q + 1'b1)] <= P_ENTER;
						end
					end
					P_FIX: begin
						x_q <= cn << 1;
						ph_q[sp_q] <= P_FIX2;
					end
					P_FIX2: begin
						lmin_q <= smin_q;
						x_q <= (cn << 1) | AW'(1);
						ph_q[sp_q] <= P_FIX3;
					end
					P_COVSET: begin
						x_q <= cn;
						ph_q[sp_q] <= P_POP;
					end
					default: ;
				endcase
			end
			W_SCHK: begin
				smin_q <= smin_new;
				mx_q   <= x_q << 1;
				mv_q   <= mem_rdata.pend;
				two_q  <= 1'b1;
			end
			W_MWR: begin
				if (two_q) begin
					two_q <= 1'b0;
					mx_q  <= mx_q | AW'(1);
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/lazy_range_add_min_tree.sv */
// channel   dir  signals                    beat carries
// s_axis    in   tvalid tready tdata tuser  one range add or range-min query
// m_axis    out  tvalid tready tdata        minimum for one query
// cfg       in   cfg_we cfg_wdata           empty_result, written on cfg_we
//
// One item at a time, one node RAM access per step. A visited node takes an entry
// read and settle, pushes to both children, and for adds the cover update or the
// fixup of both children; up to about 4*log2(LEAVES) nodes are visited per item.
// An empty add finishes at once in idle; an empty query goes straight to the result.
// After reset every node RAM entry is cleared, with s_axis_tready low.
// While the output register holds an untaken result, a finished query waits
// and s_axis_tready stays low.
`default_nettype none
module lazy_range_add_min_tree #(
	parameter int LEAVES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // range_start, range_end, add_amount, zero pad
	input  wire logic [0:0]  s_axis_tuser,  // action
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // range_min
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);
	import lrat_pkg::*;

	localparam int AW = $clog2(LEAVES) + 1;

	logic signed [31:0] empty_q, out_q, res_min;
	logic               out_vld_q, res_valid, res_ready, start, ready;
	logic               mem_we;
	logic [AW-1:0]      mem_addr;
	node_t              mem_wdata, mem_rdata;
	item_t              item;

	assign item.action      = action_t'(s_axis_tuser[0]);
	assign item.range_start = s_axis_tdata[10:0];
	assign item.range_end   = s_axis_tdata[21:11];
	assign item.add_amount  = s_axis_tdata[53:22];

	assign s_axis_tready = ready;
	assign start         = s_axis_tvalid && ready;
	assign res_ready     = !out_vld_q || m_axis_tready;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q   <= EMPTY_RESET;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				empty_q <= cfg_wdata;
			end
			if (res_valid && res_ready) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res_min;
		end
	end

	lrat_walker #(.LEAVES(LEAVES), .AW(AW)) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.empty_val (empty_q),
		.ready     (ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_min   (res_min),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	lrat_node_ram #(.AW(AW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

`ifndef SYNTHESIS
	a_res_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> m_axis_tvalid)
		else $error("query result not loaded into output register");
	a_add_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> !res_valid)
		else $error("range add raised a result");
	a_idle_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !mem_we)
		else $error("node RAM written while idle");
`endif

endmodule
`default_nettype wire
